@@ rtl/sac_pkg.sv @@
// Package: shared types, constants and class geometry for the slab allocator.
`default_nettype none
package sac_pkg;

	localparam int POOL_PAGES_DEF = 64;
	localparam int ZONE_COUNT_DEF = 2;
	localparam int CLASS_COUNT    = 8;
	localparam int HEADER_BYTES   = 16;
	localparam int BLK_W          = 7;   // block index bits within a page
	localparam logic [7:0] BLOCK_NONE = 8'hFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_DMA32     = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_A_DEC, S_A_INIT, S_A_PRD, S_A_BRD, S_A_FIN,
		S_F_CHK, S_F_DEC, S_F_FIN
	} state_t;

	typedef struct packed {
		logic    ready;
		logic    load;
		logic    init_start;
		logic    init_step;
		logic    take_head;
		logic    page_rd;
		logic    alloc_blk_rd;
		logic    alloc_commit;
		logic    free_blk_rd;
		logic    free_commit;
		logic    emit;
		status_t code;
		logic    cls_zero;
	} sac_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_op;
		logic dma32;
		logic too_large;
		logic head_null;
		logic pool_full;
		logic addr_bad;
		logic slot_bad;
		logic blk_free;
		logic init_last;
		logic out_busy;
	} sac_sts_t;

	// Block bytes per class (page of 4096 bytes with a 16-byte header)
	function automatic logic [11:0] class_bytes(input logic [2:0] c);
		logic [11:0] b;
		unique case (c)
			3'd0: b = 12'd32;
			3'd1: b = 12'd64;
			3'd2: b = 12'd128;
			3'd3: b = 12'd240;
			3'd4: b = 12'd496;
			3'd5: b = 12'd1008;
			3'd6: b = 12'd2032;
			default: b = 12'd4080;
		endcase
		return b;
	endfunction

	// Blocks per page for each class
	function automatic logic [7:0] class_count(input logic [2:0] c);
		logic [7:0] n;
		unique case (c)
			3'd0: n = 8'd127;
			3'd1: n = 8'd63;
			3'd2: n = 8'd31;
			3'd3: n = 8'd16;
			3'd4: n = 8'd8;
			3'd5: n = 8'd4;
			3'd6: n = 8'd2;
			default: n = 8'd1;
		endcase
		return n;
	endfunction

	// Map a payload offset (minus both headers) to a block index; bit 7 flags a hit
	function automatic logic [7:0] slot_decode(input logic [2:0] c, input logic [11:0] r);
		logic [7:0] res;
		logic [11:0] kb;
		res = 8'h00;
		unique case (c)
			3'd0: res = {(r[4:0] == 5'd0) && (r[11:5] < 7'd127), r[11:5]};
			3'd1: res = {(r[5:0] == 6'd0) && (r[11:6] < 6'd63), 1'b0, r[11:6]};
			3'd2: res = {(r[6:0] == 7'd0) && (r[11:7] < 5'd31), 2'b0, r[11:7]};
			default: begin
				for (int k = 0; k < 16; k++) begin
					kb = 12'(k * int'(class_bytes(c)));
					if ((8'(k) < class_count(c)) && (r == kb))
						res = {1'b1, 7'(k)};
				end
			end
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

@@ rtl/sac_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/sac_ctrl.sv @@
// Controller: sequences allocate and free transfers through the datapath.
`default_nettype none
module sac_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sac_pkg::sac_sts_t sts,
	output sac_pkg::sac_cmd_t      cmd
);
	import sac_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (sts.in_valid) state_d = sts.in_op ? S_F_CHK : S_A_DEC;
			S_A_DEC: begin
				if (sts.dma32 || sts.too_large || (sts.head_null && sts.pool_full)) begin
					if (!sts.out_busy) state_d = S_IDLE;
				end else if (sts.head_null)
					state_d = S_A_INIT;
				else
					state_d = S_A_PRD;
			end
			S_A_INIT: if (sts.init_last) state_d = S_A_PRD;
			S_A_PRD:  state_d = S_A_BRD;
			S_A_BRD:  state_d = S_A_FIN;
			S_A_FIN:  if (!sts.out_busy) state_d = S_IDLE;
			S_F_CHK: begin
				if (!sts.addr_bad)
					state_d = S_F_DEC;
				else if (!sts.out_busy)
					state_d = S_IDLE;
			end
			S_F_DEC: begin
				if (!sts.slot_bad)
					state_d = S_F_FIN;
				else if (!sts.out_busy)
					state_d = S_IDLE;
			end
			S_F_FIN:  if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.load  = sts.in_valid;
			end
			S_A_DEC: begin
				priority if (sts.dma32) begin
					cmd.emit = !sts.out_busy;
					cmd.code = ST_DMA32;
					cmd.cls_zero = 1'b1;
				end else if (sts.too_large) begin
					cmd.emit = !sts.out_busy;
					cmd.code = ST_TOO_LARGE;
					cmd.cls_zero = 1'b1;
				end else if (sts.head_null && sts.pool_full) begin
					cmd.emit = !sts.out_busy;
					cmd.code = ST_EXHAUSTED;
				end else if (sts.head_null)
					cmd.init_start = 1'b1;
				else
					cmd.take_head = 1'b1;
			end
			S_A_INIT: cmd.init_step = 1'b1;
			S_A_PRD:  cmd.page_rd = 1'b1;
			S_A_BRD:  cmd.alloc_blk_rd = 1'b1;
			S_A_FIN: begin
				cmd.alloc_commit = !sts.out_busy;
				cmd.emit = !sts.out_busy;
			end
			S_F_CHK: begin
				if (sts.addr_bad) begin
					cmd.emit = !sts.out_busy;
					cmd.code = ST_BAD_FREE;
					cmd.cls_zero = 1'b1;
				end else
					cmd.page_rd = 1'b1;
			end
			S_F_DEC: begin
				if (sts.slot_bad) begin
					cmd.emit = !sts.out_busy;
					cmd.code = ST_BAD_FREE;
					cmd.cls_zero = 1'b1;
				end else
					cmd.free_blk_rd = 1'b1;
			end
			S_F_FIN: begin
				cmd.emit = !sts.out_busy;
				if (sts.blk_free)
					cmd.code = ST_BAD_FREE;
				else
					cmd.free_commit = !sts.out_busy;
			end
			default: cmd.ready = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/sac_dp.sv @@
// Datapath: request registers, class list heads, page and block tables, result register.
`default_nettype none
module sac_dp #(
	parameter int POOL_PAGES = sac_pkg::POOL_PAGES_DEF,
	parameter int ZONE_COUNT = sac_pkg::ZONE_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sac_pkg::sac_cmd_t cmd,
	output sac_pkg::sac_sts_t      sts,
	input  wire logic              s_tvalid,
	input  wire logic [31:0]       s_tdata,
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [23:0]            m_tdata,
	output logic [2:0]             m_tuser
);
	import sac_pkg::*;

	localparam int PG_W    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int PAGES   = 1 << PG_W;
	localparam int CNT_W   = $clog2(POOL_PAGES + 1);
	localparam int HEADS   = ZONE_COUNT * CLASS_COUNT;
	localparam int H_W     = $clog2(HEADS);
	localparam int LINK_W  = PG_W + 1;
	localparam int PAGE_DW = LINK_W + 8 + 3 + 8;
	localparam int BLKS    = PAGES << BLK_W;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic [7:0]        first;
		logic [2:0]        cls;
		logic [7:0]        cnt;
	} page_ent_t;

	typedef struct packed {
		logic [7:0] next;
		logic       free;
		logic       zone;
	} blk_ent_t;

	// Request registers
	logic             op_q, zone_q, dma32_q;
	logic [11:0]      size_q;
	logic [17:0]      addr_q;
	logic [PG_W-1:0]  pg_q;
	logic [BLK_W-1:0] k_q;
	logic [CNT_W-1:0] handed_q;
	logic [LINK_W-1:0] head_q [HEADS];

	page_ent_t page_rd, page_wd;
	blk_ent_t  blk_rd, blk_wd;
	logic      page_we, blk_we;
	logic [PG_W+BLK_W-1:0] blk_waddr, blk_raddr;

	// Allocate class choice
	logic [12:0] need;
	logic [2:0]  a_cls;
	logic        big;
	always_comb begin
		need  = {1'b0, size_q} + 13'(HEADER_BYTES);
		a_cls = 3'd0;
		big   = 1'b1;
		for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
			if (need <= {1'b0, class_bytes(3'(c))}) begin
				a_cls = 3'(c);
				big   = 1'b0;
			end
		end
	end

	logic       zone_eff, fzone_eff;
	logic [H_W-1:0] a_h, f_h;
	assign zone_eff  = (ZONE_COUNT > 1) ? zone_q : 1'b0;
	assign fzone_eff = (ZONE_COUNT > 1) ? blk_rd.zone : 1'b0;
	assign a_h = H_W'(int'(zone_eff) * CLASS_COUNT + int'(a_cls));
	assign f_h = H_W'(int'(fzone_eff) * CLASS_COUNT + int'(page_rd.cls));

	// Free address decode
	logic [5:0]  f_pg;
	logic [11:0] f_off, f_r;
	logic [7:0]  f_slot;
	assign f_pg   = addr_q[17:12];
	assign f_off  = addr_q[11:0];
	assign f_r    = f_off - 12'(2 * HEADER_BYTES);
	assign f_slot = slot_decode(page_rd.cls, f_r);

	// Geometry and init walk
	logic [7:0]  a_count;
	logic [11:0] a_bytes;
	logic [BLK_W-1:0] a_k;
	logic [18:0] kb;
	logic        init_last;
	assign a_count   = class_count(a_cls);
	assign a_bytes   = class_bytes(a_cls);
	assign a_k       = page_rd.first[BLK_W-1:0];
	assign kb        = 19'(a_k * a_bytes);
	assign init_last = ({1'b0, k_q} + 8'd1) >= a_count;

	// Status to controller
	always_comb begin
		sts.in_valid  = s_tvalid;
		sts.in_op     = s_tuser;
		sts.dma32     = dma32_q;
		sts.too_large = big;
		sts.head_null = head_q[a_h][PG_W];
		sts.pool_full = 32'(handed_q) >= 32'(POOL_PAGES);
		sts.addr_bad  = (32'(f_pg) >= 32'(handed_q)) || (32'(f_pg) >= 32'(POOL_PAGES))
			|| (f_off < 12'(2 * HEADER_BYTES));
		sts.slot_bad  = !f_slot[7];
		sts.blk_free  = blk_rd.free;
		sts.init_last = init_last;
		sts.out_busy  = m_tvalid && !m_tready;
	end

	// Control registers: pool counter and class list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handed_q <= '0;
			for (int i = 0; i < HEADS; i++)
				head_q[i] <= {1'b1, {PG_W{1'b0}}};
		end else begin
			if (cmd.init_step && init_last) begin
				handed_q <= handed_q + CNT_W'(1);
				head_q[a_h] <= {1'b0, pg_q};
			end
			if (cmd.alloc_commit && (page_rd.cnt == 8'd1))
				head_q[a_h] <= page_rd.link;
			if (cmd.free_commit && (page_rd.cnt == 8'd0))
				head_q[f_h] <= {1'b0, pg_q};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= s_tuser;
			size_q  <= s_tdata[11:0];
			zone_q  <= s_tdata[12];
			dma32_q <= s_tdata[13];
			addr_q  <= s_tdata[31:14];
			pg_q    <= PG_W'(s_tdata[31:26]);
		end
		if (cmd.init_start) begin
			pg_q <= PG_W'(handed_q);
			k_q  <= '0;
		end
		if (cmd.init_step)
			k_q <= k_q + BLK_W'(1);
		if (cmd.take_head)
			pg_q <= head_q[a_h][PG_W-1:0];
	end

	// Table writes
	always_comb begin
		page_we = 1'b0;
		page_wd = page_rd;
		blk_we  = 1'b0;
		blk_wd  = blk_rd;
		blk_waddr = {pg_q, op_q ? f_slot[BLK_W-1:0] : a_k};
		if (cmd.init_step) begin
			blk_we    = 1'b1;
			blk_waddr = {pg_q, k_q};
			blk_wd.next = init_last ? BLOCK_NONE : ({1'b0, k_q} + 8'd1);
			blk_wd.free = 1'b1;
			blk_wd.zone = zone_eff;
			page_we      = init_last;
			page_wd.link = head_q[a_h];
			page_wd.first = 8'd0;
			page_wd.cls  = a_cls;
			page_wd.cnt  = a_count;
		end else if (cmd.alloc_commit) begin
			blk_we = 1'b1;
			blk_wd.free = 1'b0;
			blk_wd.zone = zone_eff;
			page_we = 1'b1;
			page_wd.first = blk_rd.next;
			page_wd.cnt   = page_rd.cnt - 8'd1;
			if (page_rd.cnt == 8'd1)
				page_wd.link = {1'b1, {PG_W{1'b0}}};
		end else if (cmd.free_commit) begin
			blk_we = 1'b1;
			blk_wd.free = 1'b1;
			blk_wd.next = page_rd.first;
			page_we = 1'b1;
			page_wd.first = {1'b0, f_slot[BLK_W-1:0]};
			page_wd.cnt   = page_rd.cnt + 8'd1;
			if (page_rd.cnt == 8'd0)
				page_wd.link = head_q[f_h];
		end
	end

	assign blk_raddr = {pg_q, op_q ? f_slot[BLK_W-1:0] : a_k};

	sac_ram #(.WIDTH(PAGE_DW), .DEPTH(PAGES)) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (pg_q),
		.wdata (page_wd),
		.re    (cmd.page_rd),
		.raddr (pg_q),
		.rdata (page_rd)
	);

	sac_ram #(.WIDTH(10), .DEPTH(BLKS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wd),
		.re    (cmd.alloc_blk_rd || cmd.free_blk_rd),
		.raddr (blk_raddr),
		.rdata (blk_rd)
	);

	// Result register: hold until the transfer completes
	logic [2:0] res_cls;
	assign res_cls = cmd.cls_zero ? 3'd0 : (op_q ? page_rd.cls : a_cls);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.emit)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tuser <= cmd.code;
			m_tdata <= {3'b0, res_cls,
				cmd.alloc_commit ? (18'({pg_q, 12'h020}) + 18'(kb)) : 18'd0};
		end
	end

endmodule
`default_nettype wire

@@ rtl/slab_size_class_allocator_top.sv @@
// Top level: slab allocator with eight size classes, controller plus datapath.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser op; tdata size, zone, dma32, address
//  m_*       out  m_tvalid/m_tready  tuser status; tdata block_address, size_class
//
// An allocate from a non-empty class list passes decode, page read, block read and
// finish; one taking a fresh page first walks its chain of blocks (1 to 127) through
// the block table write port. A free or a double free passes address check, slot
// decode and finish; a size, zone, pool, address or slot rejection ends in its check.
// Reset clears the class list heads and the page counter; tables need no clear.
// A stalled result holds in the output register; the next transfer is taken
// meanwhile and waits only at its own result.
`default_nettype none
module slab_size_class_allocator_top #(
	parameter int POOL_PAGES = sac_pkg::POOL_PAGES_DEF,
	parameter int ZONE_COUNT = sac_pkg::ZONE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // request_size[11:0], zone_dma16, want_dma32, address
	input  wire logic        s_tuser,  // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // block_address[17:0], size_class[2:0], zero pad
	output logic [2:0]       m_tuser   // status
);
	import sac_pkg::*;

	sac_cmd_t cmd;
	sac_sts_t sts;

	assign s_tready = cmd.ready;

	sac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sac_dp #(.POOL_PAGES(POOL_PAGES), .ZONE_COUNT(ZONE_COUNT)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

@@ dv/sac_checker.sv @@
// Checker: watches both channels, predicts allocator results and compares them.
`timescale 1ns / 100ps
module sac_checker
	import sac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic [2:0]  m_tuser,
	output int               fail_count,
	output int               pending
);
	localparam int PAGES = 64;
	localparam int NO_PAGE = -1;
	localparam int NO_BLOCK = 255;

	typedef struct packed {
		status_t     st;
		logic [17:0] addr;
		logic [2:0]  cls;
	} alloc_result_t;

	// Allocator shadow state
	int            head_page [16];
	int            page_link [PAGES];
	int            page_free_head [PAGES];
	int            page_cls [PAGES];
	int            page_free_cnt [PAGES];
	int            blk_next [PAGES*128];
	bit            blk_free [PAGES*128];
	bit            blk_zone [PAGES*128];
	int            pages_used;
	alloc_result_t results_due [$];

	// Block bytes and block count of a size class
	function automatic void geometry(input int c, output int bytes, output int count);
		int gross;
		gross = 32 << c;
		if (gross >= 4096) begin
			count = 1;
			bytes = gross - 16;
		end else if (gross >= 256) begin
			count = 4096 / gross;
			bytes = (4080 / count) & 'hFFF0;
		end else begin
			count = 4080 / gross;
			bytes = gross;
		end
	endfunction

	function automatic alloc_result_t allocate(input int size, input bit zone, input bit dma32);
		alloc_result_t r;
		int c, bytes, count, h, pg, k, bi;
		r = '{ST_OK, 18'd0, 3'd0};
		if (dma32) begin
			r.st = ST_DMA32;
			return r;
		end
		for (c = 0; c < 8; c++) begin
			geometry(c, bytes, count);
			if (size + 16 <= bytes)
				break;
		end
		if (c >= 8) begin
			r.st = ST_TOO_LARGE;
			return r;
		end
		r.cls = 3'(c);
		h = int'(zone) * 8 + c;
		pg = head_page[h];
		if (pg == NO_PAGE) begin
			if (pages_used >= PAGES) begin
				r.st = ST_EXHAUSTED;
				return r;
			end
			pg = pages_used++;
			for (k = 0; k < count; k++) begin
				bi = pg * 128 + k;
				blk_next[bi] = (k + 1 < count) ? k + 1 : NO_BLOCK;
				blk_free[bi] = 1'b1;
				blk_zone[bi] = zone;
			end
			page_free_head[pg] = 0;
			page_free_cnt[pg] = count;
			page_cls[pg] = c;
			page_link[pg] = NO_PAGE;
			head_page[h] = pg;
		end
		// pop the first free block of the head page
		k = page_free_head[pg] & 127;
		bi = pg * 128 + k;
		page_free_head[pg] = blk_next[bi];
		page_free_cnt[pg]--;
		if (page_free_cnt[pg] == 0) begin
			head_page[h] = page_link[pg];
			page_link[pg] = NO_PAGE;
		end
		blk_free[bi] = 1'b0;
		blk_zone[bi] = zone;
		r.addr = 18'(pg * 4096 + 32 + k * bytes);
		return r;
	endfunction

	function automatic alloc_result_t release_block(input int addr);
		alloc_result_t r;
		int pg, off, c, bytes, count, rem, k, bi, h;
		r = '{ST_BAD_FREE, 18'd0, 3'd0};
		pg = addr / 4096;
		off = addr % 4096;
		if (pg >= pages_used || off < 32)
			return r;
		c = page_cls[pg];
		geometry(c, bytes, count);
		rem = off - 32;
		if (rem % bytes != 0 || rem / bytes >= count)
			return r;
		r.cls = 3'(c);
		k = rem / bytes;
		bi = pg * 128 + k;
		if (blk_free[bi])
			return r;
		// push back; a page coming back from full rejoins its list
		h = int'(blk_zone[bi]) * 8 + c;
		blk_free[bi] = 1'b1;
		blk_next[bi] = page_free_head[pg];
		page_free_head[pg] = k;
		page_free_cnt[pg]++;
		if (page_free_cnt[pg] == 1) begin
			page_link[pg] = head_page[h];
			head_page[h] = pg;
		end
		r.st = ST_OK;
		return r;
	endfunction

	// Compare result transfers, then predict for request transfers
	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				head_page[i] = NO_PAGE;
			pages_used = 0;
			results_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d addr %h class %0d",
							m_tuser, m_tdata[17:0], m_tdata[20:18]);
				end else begin
					want = results_due.pop_front();
					if (m_tuser !== want.st || m_tdata[17:0] !== want.addr ||
							m_tdata[20:18] !== want.cls || m_tdata[23:21] !== 3'd0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp status %0d addr %h class %0d, got %0d %h %0d",
								want.st, want.addr, want.cls,
								m_tuser, m_tdata[17:0], m_tdata[20:18]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser)
					results_due.push_back(release_block(int'(s_tdata[31:14])));
				else
					results_due.push_back(allocate(int'(s_tdata[11:0]), s_tdata[12],
						s_tdata[13]));
			end
			pending = results_due.size();
		end
	end
endmodule

@@ dv/tb_slab_size_class_allocator_top.sv @@
// Testbench top: request stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps
module tb_slab_size_class_allocator_top;
	import sac_pkg::*;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
	localparam int   CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	int          fail_count, pending;
	int          cycles = 0;
	int          gap_max = 14;
	int          stall_max = 14;
	int          stall_left = 0;
	logic [17:0] live_blocks [$];
	logic [17:0] freed_blocks [$];

	slab_size_class_allocator_top dut (.*);

	sac_checker checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Random back-pressure; collect live block addresses for frees
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (m_tuser == ST_OK && m_tdata[17:0] != 18'd0)
				live_blocks.push_back(m_tdata[17:0]);
			stall_left = $urandom_range(0, stall_max);
		end else if (stall_left > 0)
			stall_left--;
		m_tready <= (stall_left == 0);
	end

	task automatic send(input logic op, input int size, input bit zone, input bit dma32,
			input logic [17:0] addr);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {addr, dma32, zone, 12'(size)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic free_live(input bit zone);
		int i;
		logic [17:0] a;
		if (live_blocks.size() == 0) begin
			send(OP_FREE, $urandom, zone, 1'($urandom), 18'($urandom));
			return;
		end
		i = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[i];
		live_blocks.delete(i);
		freed_blocks.push_back(a);
		if (freed_blocks.size() > 16)
			void'(freed_blocks.pop_front());
		send(OP_FREE, $urandom, zone, 1'($urandom), a);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int sel, c, top_size;
		bit zone;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: class boundaries, extremes, errors, frees
		for (int k = 0; k < 8; k++)
			send(OP_ALLOC, (k == 0) ? 16 : ((32 << k) - 16 - ((k >= 3) ? 16 : 0)),
				k[0], 1'b0, 18'h0);
		send(OP_ALLOC, 0, 1'b0, 1'b0, 18'h3FFFF);
		send(OP_ALLOC, 17, 1'b1, 1'b0, 18'h0);
		send(OP_ALLOC, 4064, 1'b0, 1'b0, 18'h0);
		send(OP_ALLOC, 4065, 1'b0, 1'b0, 18'h0);
		send(OP_ALLOC, 4095, 1'b1, 1'b0, 18'h0);
		send(OP_ALLOC, 4095, 1'b1, 1'b1, 18'h0);
		send(OP_ALLOC, 0, 1'b0, 1'b1, 18'h3FFFF);
		wait_drained();
		free_live(1'b1);
		send(OP_FREE, 0, 1'b0, 1'b0, freed_blocks[$]);
		send(OP_FREE, 0, 1'b0, 1'b0, 18'h0);
		send(OP_FREE, 0, 1'b0, 1'b0, 18'd33);
		send(OP_FREE, 4095, 1'b1, 1'b1, 18'h3FFFF);
		send(OP_FREE, 0, 1'b0, 1'b0, 18'd31);
		free_live(1'b0);
		free_live(1'b1);

		// Random: mostly well-formed allocate/free traffic
		for (int n = 0; n < 550; n++) begin
			if (n % 50 == 0) begin
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
				stall_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			end
			if (n == 275)
				wait_drained();
			sel = $urandom_range(0, 99);
			zone = 1'($urandom);
			if (sel < 55) begin
				c = $urandom_range(0, 7);
				top_size = (c == 7) ? 4064 : (32 << c);
				if ($urandom_range(0, 19) == 0)
					send(OP_ALLOC, $urandom_range(0, 4095), zone,
						$urandom_range(0, 9) == 0, 18'($urandom));
				else
					send(OP_ALLOC, $urandom_range(0, top_size), zone,
						$urandom_range(0, 29) == 0, 18'($urandom));
			end else if (sel < 88)
				free_live(zone);
			else if (sel < 93 && freed_blocks.size() != 0)
				send(OP_FREE, $urandom, zone, 1'($urandom),
					freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
			else
				send(OP_FREE, $urandom, zone, 1'($urandom), 18'($urandom));
		end

		// Drain and settle
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
